@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising clk edge outside reset.
`define ASSERT_IMPL(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Check an implication in the next cycle, outside reset.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// Check a condition on every rising clk edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

`endif

@@ src/mbe_pkg.sv @@
// Package: widths, constants, types and saturation helpers of the escape-time block.
`default_nettype none

package mbe_pkg;

	localparam int PIXEL_BITS    = 10;
	localparam int FRACTION_BITS = 28;

	localparam int WORD_W     = 32;
	localparam int STEP_W     = 29;
	localparam int COUNT_W    = 8;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam int PROD_W  = PIXEL_BITS + STEP_W;
	localparam int MAP_W   = PROD_W + 2;
	localparam int SQ_W    = 2 * WORD_W;
	localparam int WIDE_W  = SQ_W + 1;
	localparam int ESC_BIT = 2 * FRACTION_BITS + 2;

	localparam int IN_PAY_W  = 2 * PIXEL_BITS;
	localparam int IN_W      = ((IN_PAY_W + 7) / 8) * 8;
	localparam int OUT_PAY_W = 2 * PIXEL_BITS + 2 * COUNT_W;
	localparam int OUT_W     = ((OUT_PAY_W + 7) / 8) * 8;

	localparam longint LIM_L    = longint'(1) << (FRACTION_BITS + 2);
	localparam longint S32_MAX_L = 64'sd2147483647;
	localparam longint S32_MIN_L = -64'sd2147483648;
	localparam longint MAP_HI_L = (LIM_L < S32_MAX_L) ? LIM_L : S32_MAX_L;
	localparam longint MAP_LO_L = (-LIM_L > S32_MIN_L) ? -LIM_L : S32_MIN_L;

	localparam logic signed [MAP_W-1:0]  MAP_HI   = MAP_W'(MAP_HI_L);
	localparam logic signed [MAP_W-1:0]  MAP_LO   = MAP_W'(MAP_LO_L);
	localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(S32_MAX_L);
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(S32_MIN_L);

	localparam logic signed [WORD_W-1:0] ORIGIN_RESET = -32'sd536870912;
	localparam logic [STEP_W-1:0]        STEP_RESET   = 29'd1789570;
	localparam logic [COUNT_W-1:0]       CAP_RESET    = 8'd255;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_ORIGIN_REAL = 2'd0,
		REG_ORIGIN_IMAG = 2'd1,
		REG_PIXEL_STEP  = 2'd2,
		REG_ITER_CAP    = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAP,
		ST_INIT,
		ST_SQUARE,
		ST_TEST,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load_in;
		logic map;
		logic init;
		logic square;
		logic step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} dp_status_t;

	function automatic logic signed [WORD_W-1:0] clamp_map(input logic signed [MAP_W-1:0] v);
		logic signed [MAP_W-1:0] r;
		r = v;
		if (v > MAP_HI) r = MAP_HI;
		if (v < MAP_LO) r = MAP_LO;
		return r[WORD_W-1:0];
	endfunction

	function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (v > WIDE_MAX) r = WIDE_MAX;
		if (v < WIDE_MIN) r = WIDE_MIN;
		return r[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

@@ src/mbe_ctrl.sv @@
// Controller: sequences mapping, square and update steps for one pixel at a time.
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MAP;
				end
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_INIT;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_TEST;
			end
			ST_TEST: begin
				if (status.done) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_SQUARE;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/mbe_dp.sv @@
// Datapath: configuration registers, point mapping, complex square, escape test, result beat.
`default_nettype none

module mbe_dp import mbe_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [CFG_ADDR_W-1:0] cfg_addr,
	input  wire  [CFG_DATA_W-1:0] cfg_wdata,
	input  wire  [IN_W-1:0]       in_data,
	input  wire                   out_ready,
	input  dp_cmd_t               cmd,
	output dp_status_t            status,
	output logic                  out_valid,
	output logic [OUT_W-1:0]      out_data
);

	logic signed [WORD_W-1:0] origin_re_q, origin_im_q;
	logic [STEP_W-1:0]        step_q;
	logic [COUNT_W-1:0]       cap_q;

	logic [PIXEL_BITS-1:0]    px_q, py_q;
	logic [PROD_W-1:0]        prod_re_s1, prod_im_s1;
	logic signed [WORD_W-1:0] c_re_q, c_im_q, z_re_q, z_im_q;
	logic signed [SQ_W-1:0]   rr_s1, ii_s1, ri_s1;
	logic [COUNT_W-1:0]       count_q;
	logic                     out_valid_q;
	logic [OUT_W-1:0]         out_data_q;

	logic signed [MAP_W-1:0]  map_re, map_im;
	logic [WIDE_W-1:0]        mag_sum;
	logic                     escaped;
	logic signed [SQ_W-1:0]   re_diff, re_sh, im_sh;
	logic signed [WIDE_W-1:0] re_sum, im_sum;
	logic [COUNT_W-1:0]       blue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= ORIGIN_RESET;
			origin_im_q <= ORIGIN_RESET;
			step_q      <= STEP_RESET;
			cap_q       <= CAP_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_ORIGIN_REAL: origin_re_q <= $signed(cfg_wdata[WORD_W-1:0]);
				REG_ORIGIN_IMAG: origin_im_q <= $signed(cfg_wdata[WORD_W-1:0]);
				REG_PIXEL_STEP:  step_q      <= cfg_wdata[STEP_W-1:0];
				REG_ITER_CAP:    cap_q       <= cfg_wdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		map_re = $signed({{(MAP_W-WORD_W){origin_re_q[WORD_W-1]}}, origin_re_q})
			+ $signed({{(MAP_W-PROD_W){1'b0}}, prod_re_s1});
		map_im = $signed({{(MAP_W-WORD_W){origin_im_q[WORD_W-1]}}, origin_im_q})
			+ $signed({{(MAP_W-PROD_W){1'b0}}, prod_im_s1});

		mag_sum = {1'b0, rr_s1} + {1'b0, ii_s1};
		escaped = |mag_sum[WIDE_W-1:ESC_BIT];

		re_diff = rr_s1 - ii_s1;
		re_sh   = re_diff >>> FRACTION_BITS;
		im_sh   = ri_s1 >>> (FRACTION_BITS - 1);
		re_sum  = $signed({re_sh[SQ_W-1], re_sh})
			+ $signed({{(WIDE_W-WORD_W){c_re_q[WORD_W-1]}}, c_re_q});
		im_sum  = $signed({im_sh[SQ_W-1], im_sh})
			+ $signed({{(WIDE_W-WORD_W){c_im_q[WORD_W-1]}}, c_im_q});

		blue = cap_q - count_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			px_q <= in_data[PIXEL_BITS-1:0];
			py_q <= in_data[2*PIXEL_BITS-1:PIXEL_BITS];
		end
		if (cmd.map) begin
			prod_re_s1 <= PROD_W'(px_q) * PROD_W'(step_q);
			prod_im_s1 <= PROD_W'(py_q) * PROD_W'(step_q);
		end
		if (cmd.init) begin
			c_re_q <= clamp_map(map_re);
			c_im_q <= clamp_map(map_im);
			z_re_q <= clamp_map(map_re);
			z_im_q <= clamp_map(map_im);
		end
		if (cmd.square) begin
			rr_s1 <= SQ_W'(z_re_q) * SQ_W'(z_re_q);
			ii_s1 <= SQ_W'(z_im_q) * SQ_W'(z_im_q);
			ri_s1 <= SQ_W'(z_re_q) * SQ_W'(z_im_q);
		end
		if (cmd.step) begin
			z_re_q <= sat_word(re_sum);
			z_im_q <= sat_word(im_sum);
		end
		if (cmd.load_out) begin
			out_data_q <= OUT_W'({blue, count_q, py_q, px_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.init) begin
				count_q <= '0;
			end else if (cmd.step) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.done     = escaped || (count_q == cap_q);
	assign status.out_free = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign out_data        = out_data_q;

endmodule

`default_nettype wire

@@ src/mandelbrot_escape_iterations.sv @@
// Top level: escape-time counter for one pixel per input beat, stream in and stream out.
`default_nettype none

`include "assert_macros.svh"

// Each input beat carries a pixel (x, y). The pixel is mapped to the point
// c = origin + x*step + i*y*step (signed Q4.28, each part held to +/-4.0),
// z = z*z + c is iterated from z = c, and one result beat returns x, y, the
// number of iterations done before |z|^2 >= 4 (at most iteration_cap) and
// the blue level iteration_cap - count. One pixel is in work at a time: a
// new pixel is taken only once the last result is in the output register,
// which waits until that register is free. Each iteration runs the square
// step, whose three 32x32 multipliers are registered and then feed the
// escape compare and update. A finished result waits in the output register
// while the next pixel is taken. Write configuration only while idle.
module mandelbrot_escape_iterations import mbe_pkg::*; (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire  [CFG_ADDR_W-1:0] cfg_addr,
	input  wire  [CFG_DATA_W-1:0] cfg_wdata,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	input  wire  [IN_W-1:0]       s_axis_tdata,  // pixel_x, pixel_y, zero pad
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [OUT_W-1:0]      m_axis_tdata   // out_x, out_y, escape_count, blue_level, pad
);

	dp_cmd_t    cmd;
	dp_status_t status;

	mbe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mbe_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_axis_tdata),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata)
	);

	`ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "more than one datapath command at once")
	`ASSERT_IMPL(a_no_overwrite, cmd.load_out, status.out_free, "result beat overwritten")
	`ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
		"input taken while a pixel is in work")

endmodule

`default_nettype wire
